FILE: rtl/bfha_pkg.sv
// Package for the best-fit heap allocator: widths, status codes, defaults.
// No dependencies.
`timescale 1ns / 1ps
package bfha_pkg;
    localparam int HEAP_BYTES_DEF = 4096;
    localparam int REQ_W = 13;
    localparam int OFF_W = 12;
    localparam int STAT_W = 3;

    localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
    localparam logic [STAT_W-1:0] ST_INVALID = 3'd1;
    localparam logic [STAT_W-1:0] ST_NOFIT   = 3'd2;
    localparam logic [STAT_W-1:0] ST_OUTSIDE = 3'd3;
    localparam logic [STAT_W-1:0] ST_DOUBLE  = 3'd4;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic                 operation;
        logic [REQ_W-1:0]     request_bytes;
        logic [OFF_W-1:0]     block_offset;
    } t_req;

    typedef struct packed {
        logic [STAT_W-1:0]    status;
        logic [OFF_W-1:0]     payload_offset;
    } t_rsp;
endpackage

FILE: rtl/bfha_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on bfha_pkg.
`timescale 1ns / 1ps
interface bfha_req_if;
    logic             valid;
    logic             ready;
    bfha_pkg::t_req   payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface bfha_rsp_if;
    logic             valid;
    logic             ready;
    bfha_pkg::t_rsp   payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/bfha_ram.sv
// Generic single-port synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module bfha_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Read returns the old word when the same entry is written in that cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

FILE: rtl/best_fit_heap_allocator.sv
// Best-fit heap allocator over an implicit block list held in one RAM.
// Depends on bfha_pkg, bfha_if, bfha_ram.
//
// Usage: requests arrive on i_req (operation, request_bytes, block_offset);
// exactly one response (status, payload_offset) leaves on o_rsp per request.
// A request rejected on its fields alone skips the walk and goes to S_DONE.
// Allocate walks every block header from the heap start (S_WRD, S_WCHK per
// block), then writes the chosen block's header and, if it is split, the free
// rest's header and footer, else the next block's previous-allocated bit.
// Free walks to the target block the same way, then reads the next header
// and, if the previous block is free, its header, writes header and footer
// and clears the previous-allocated bit of the following block.
// One request is in work at a time; the single RAM port sets the pace, and
// a new request is taken the cycle after the previous response is loaded.
// After reset the block formats the heap: a clearing pass writes every word
// (all HEAP_BYTES/4 of them), laying down one free block and the end mark,
// and no request is accepted until it finishes.
// The response sits in an output register; if the receiver stalls it holds
// there, and the next request may already be accepted and worked on, only
// its own response waits until the register is free.
`timescale 1ns / 1ps
module best_fit_heap_allocator #(
    parameter int HEAP_BYTES = bfha_pkg::HEAP_BYTES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bfha_req_if.sink     i_req,
    bfha_rsp_if.source   o_rsp
);
    import bfha_pkg::*;

    localparam int WORDS = HEAP_BYTES / 4;
    localparam int AW    = $clog2(WORDS);
    localparam int BW    = AW + 2;             // byte address width
    localparam logic [BW-1:0] END_B   = BW'(HEAP_BYTES - 4);
    localparam logic [BW-1:0] FIRST_B = BW'(4);

    typedef enum logic [13:0] {
        S_CLEAR = 14'b00000000000001,
        S_IDLE  = 14'b00000000000010,
        S_WRD   = 14'b00000000000100,  // walk: wait read
        S_WCHK  = 14'b00000000001000,  // walk: examine header
        S_AW1   = 14'b00000000010000,  // alloc writes
        S_AW2   = 14'b00000000100000,
        S_AW3   = 14'b00000001000000,
        S_ANR   = 14'b00000010000000,  // alloc: read next header
        S_FPR   = 14'b00000100000000,  // free: read prev header
        S_FNR   = 14'b00001000000000,  // free: read next header
        S_FW1   = 14'b00010000000000,
        S_FAR   = 14'b00100000000000,  // free: read block after merge
        S_FW3   = 14'b01000000000000,
        S_DONE  = 14'b10000000000000
    } t_state;

    t_state r_state, n_state;
    logic [AW-1:0]   r_clr;
    logic            r_op;
    logic [BW:0]     r_need;
    logic [BW-1:0]   r_h;
    logic [BW-1:0]   r_pos, r_prev, r_best, r_b;
    logic [BW:0]     r_bsize, r_s;
    logic            r_found, r_have_prev;
    logic [1:0]      r_pbit;
    logic [1:0]      r_sub;
    logic            r_rv;
    t_rsp            r_rsp, r_pend;
    logic            r_pend_v;

    logic            ram_we;
    logic [BW-1:0]   ram_b;
    logic [31:0]     ram_wd, ram_rd;

    bfha_ram #(.WIDTH(32), .DEPTH(WORDS)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_b[BW-1:2]),
        .i_wdata(ram_wd),
        .o_rdata(ram_rd)
    );

    // header decode of the word just read at r_pos
    logic [BW:0] hsz, lim;
    logic        hvalid;
    always_comb begin
        hsz    = {ram_rd[BW:3], 3'b000};
        lim    = {1'b0, END_B} - {1'b0, r_pos};
        hvalid = (ram_rd[31:BW+1] == '0) && !ram_rd[2] && (hsz != '0) && (hsz <= lim);
    end

    logic [BW:0] pos_nx;
    assign pos_nx = {1'b0, r_pos} + hsz;

    // requests answered without a heap walk
    logic              early_done;
    logic [STAT_W-1:0] early_st;
    always_comb begin
        early_done = 1'b1;
        early_st   = ST_OK;
        if (i_req.payload.operation == OP_ALLOC) begin
            if (i_req.payload.request_bytes == '0)
                early_st = ST_INVALID;
            else if (32'(i_req.payload.request_bytes) + 32'd11 > 32'(HEAP_BYTES))
                early_st = ST_NOFIT;
            else
                early_done = 1'b0;
        end else if (i_req.payload.block_offset[2:0] != 3'd0) begin
            early_st = ST_INVALID;
        end else if (i_req.payload.block_offset < 12'd8
            || 32'(i_req.payload.block_offset) - 32'd4 >= 32'(END_B)) begin
            early_st = ST_OUTSIDE;
        end else begin
            early_done = 1'b0;
        end
    end

    assign i_req.ready = (r_state == S_IDLE);

    // RAM access and next state
    always_comb begin
        n_state = r_state;
        ram_we  = 1'b0;
        ram_b   = r_pos;
        ram_wd  = '0;
        case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
                ram_b  = {r_clr, 2'b00};
                if (ram_b == FIRST_B)
                    ram_wd = 32'({1'b0, END_B - FIRST_B}) | 32'd2;
                else if (ram_b == END_B - BW'(4))
                    ram_wd = 32'(END_B - FIRST_B);
                else if (ram_b == END_B)
                    ram_wd = 32'd1;
                if (r_clr == AW'(WORDS - 1)) n_state = S_IDLE;
            end
            S_IDLE:  ram_b = FIRST_B;
            S_WRD:   n_state = S_WCHK;
            S_AW1: begin
                ram_we = 1'b1;
                ram_b  = r_best;
                ram_wd = (r_sub == 2'd1)
                    ? (32'(r_need) | 32'd1 | 32'(r_pbit))
                    : (32'(r_bsize) | 32'd1 | 32'(r_pbit));
            end
            S_AW2: begin
                ram_we = 1'b1;
                ram_b  = BW'({1'b0, r_best} + r_need);
                ram_wd = 32'(r_bsize - r_need) | 32'd2;
            end
            S_AW3: begin
                ram_we = 1'b1;
                ram_b  = BW'({1'b0, r_best} + r_bsize - BW'(4));
                ram_wd = 32'(r_bsize - r_need);
            end
            S_ANR: begin
                ram_b = r_pos;
                if (r_rv) begin
                    ram_we = 1'b1;
                    ram_wd = ram_rd | 32'd2;
                end
            end
            S_FPR, S_FNR, S_FAR: ram_b = r_pos;
            S_FW1: begin
                ram_we = 1'b1;
                ram_b  = r_sub[0] ? BW'({1'b0, r_b} + r_s - BW'(4)) : r_b;
                ram_wd = r_sub[0] ? 32'(r_s) : (32'(r_s) | 32'(r_pbit));
            end
            S_FW3: begin
                ram_b = r_pos;
                if (r_rv) begin
                    ram_we = 1'b1;
                    ram_wd = ram_rd & ~32'd2;
                end
            end
            default: ;
        endcase
    end

    // control and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_rv     <= 1'b0;
            r_sub    <= '0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_clr   <= r_clr + AW'(1);
                    r_state <= n_state;
                end
                S_IDLE: if (i_req.valid) begin
                    r_op        <= i_req.payload.operation;
                    r_need      <= (BW+1)'((14'(i_req.payload.request_bytes) + 14'd11)
                                   & ~14'd7);
                    r_h         <= BW'(i_req.payload.block_offset) - BW'(4);
                    r_pos       <= FIRST_B;
                    r_found     <= 1'b0;
                    r_have_prev <= 1'b0;
                    r_rsp       <= t_rsp'{status: early_st, payload_offset: '0};
                    r_state     <= early_done ? S_DONE : S_WRD;
                end
                S_WRD: r_state <= n_state;
                S_WCHK: begin
                    if (r_op == OP_ALLOC) begin
                        if (hvalid && !ram_rd[0] && hsz >= r_need
                            && (!r_found || hsz < r_bsize)) begin
                            r_found <= 1'b1;
                            r_best  <= r_pos;
                            r_bsize <= hsz;
                            r_pbit  <= {ram_rd[1], 1'b0};
                        end
                        if (hvalid && pos_nx < {1'b0, END_B}) begin
                            r_pos   <= BW'(pos_nx);
                            r_state <= S_WRD;
                        end else if (r_found || (hvalid && !ram_rd[0]
                                     && hsz >= r_need)) begin
                            r_sub   <= 2'd0;
                            r_state <= S_AW1;
                        end else begin
                            r_rsp.status <= ST_NOFIT;
                            r_state <= S_DONE;
                        end
                    end else begin
                        if (!hvalid) begin
                            r_rsp.status <= ST_OUTSIDE;
                            r_state <= S_DONE;
                        end else if ({1'b0, r_h} < pos_nx) begin
                            r_bsize <= hsz;
                            if (r_pos != r_h)
                                r_rsp.status <= ram_rd[0] ? ST_INVALID : ST_DOUBLE;
                            else if (!ram_rd[0])
                                r_rsp.status <= ST_DOUBLE;
                            if (r_pos != r_h || !ram_rd[0]) begin
                                r_state <= S_DONE;
                            end else begin
                                r_b    <= r_h;
                                r_s    <= hsz;
                                r_pbit <= {ram_rd[1], 1'b0};
                                r_rv   <= 1'b0;
                                if (!ram_rd[1] && r_have_prev) begin
                                    r_pos   <= r_prev;
                                    r_state <= S_FPR;
                                end else begin
                                    r_pos   <= BW'(pos_nx);
                                    r_state <= S_FNR;
                                end
                            end
                        end else begin
                            r_prev      <= r_pos;
                            r_have_prev <= 1'b1;
                            if (pos_nx < {1'b0, END_B}) begin
                                r_pos   <= BW'(pos_nx);
                                r_state <= S_WRD;
                            end else begin
                                r_rsp.status <= ST_OUTSIDE;
                                r_state <= S_DONE;
                            end
                        end
                    end
                end
                S_AW1: begin
                    // after the header: split or fix next block's pbit
                    if (r_sub == 2'd0) begin
                        if (r_bsize - r_need >= (BW+1)'(8)) r_sub <= 2'd1;
                        else begin
                            r_sub <= 2'd2;
                            r_pos <= BW'({1'b0, r_best} + r_bsize);
                            r_rv  <= 1'b0;
                            if ({1'b0, r_best} + r_bsize < {1'b0, END_B})
                                r_state <= S_ANR;
                            else r_state <= S_DONE;
                        end
                        if (r_bsize - r_need >= (BW+1)'(8)) r_state <= S_AW1;
                    end else r_state <= S_AW2;
                    r_rsp.payload_offset <= OFF_W'(r_best + BW'(4));
                end
                S_AW2: r_state <= S_AW3;
                S_AW3: r_state <= S_DONE;
                S_ANR: begin
                    r_rv <= 1'b1;
                    if (r_rv) r_state <= S_DONE;
                end
                S_FPR: begin
                    if (r_rv) begin
                        r_rv <= 1'b0;
                        if (!ram_rd[0]) begin
                            r_s    <= r_s + ({1'b0, r_h} - {1'b0, r_prev});
                            r_b    <= r_prev;
                            r_pbit <= {ram_rd[1], 1'b0};
                        end
                        r_pos   <= BW'({1'b0, r_h} + r_bsize);
                        r_state <= S_FNR;
                    end else begin
                        r_rv <= 1'b1;
                    end
                end
                S_FNR: begin
                    if ({1'b0, r_pos} >= {1'b0, END_B}) begin
                        r_sub <= 2'd0;
                        r_state <= S_FW1;
                    end else if (r_rv) begin
                        r_rv <= 1'b0;
                        if (!ram_rd[0] && hvalid) r_s <= r_s + hsz;
                        r_sub   <= 2'd0;
                        r_state <= S_FW1;
                    end else begin
                        r_rv <= 1'b1;
                    end
                end
                S_FW1: begin
                    r_sub <= 2'd1;
                    if (r_sub[0]) begin
                        r_pos <= BW'({1'b0, r_b} + r_s);
                        r_rv  <= 1'b0;
                        if ({1'b0, r_b} + r_s < {1'b0, END_B}) r_state <= S_FAR;
                        else r_state <= S_DONE;
                    end
                end
                S_FAR: begin
                    r_rv <= 1'b0;
                    r_state <= S_FW3;
                end
                S_FW3: begin
                    r_rv <= 1'b1;
                    if (r_rv) r_state <= S_DONE;
                end
                S_DONE: if (!r_pend_v || o_rsp.ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // output register: load when empty or being emptied this cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
        end else if (r_state == S_DONE && (!r_pend_v || o_rsp.ready)) begin
            r_pend   <= r_rsp;
            r_pend_v <= 1'b1;
        end else if (o_rsp.ready) begin
            r_pend_v <= 1'b0;
        end
    end

    assign o_rsp.valid   = r_pend_v;
    assign o_rsp.payload = r_pend;

`ifndef SYNTHESIS
    // no request is taken while the heap is being formatted
    a_no_req_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !i_req.ready)
        else $error("request accepted during clear");
    // a held response stays put while the receiver stalls
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.ready) |=> (o_rsp.valid && $stable(o_rsp.payload)))
        else $error("response changed under stall");
    // a failed request never reports an offset
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.payload.status != ST_OK)
            |-> (o_rsp.payload.payload_offset == '0))
        else $error("offset on failed request");
`endif
endmodule
